// ===== rtl/aarm_pkg.sv =====
// Shared types, constants and arithmetic helpers for the axis-angle rotation matrix core.
`default_nettype none
package aarm_pkg;

   localparam int FRAC_BITS    = 14;
   localparam int CORDIC_STEPS = 16;
   localparam int IN_W         = 16;
   localparam int Q_W          = 34;   // Q30 working values
   localparam int UV_W         = 2 * IN_W;
   localparam int PH_W         = UV_W + Q_W - 16;
   localparam int PL_W         = UV_W + 17;
   localparam int SN_W         = IN_W + Q_W;
   localparam int PW           = UV_W + Q_W + 1;
   localparam int E_W          = 40;
   localparam int NUM_ROWS     = 4;

   localparam int ANG_SHIFT   = 31 - FRAC_BITS;
   localparam int OUTER_SHIFT = 2 * FRAC_BITS;
   localparam int SIN_SHIFT   = FRAC_BITS;
   localparam int RND_SHIFT   = 30 - FRAC_BITS;

   localparam logic signed [Q_W-1:0] Q30_ONE     = 34'sd1073741824;
   localparam logic signed [Q_W-1:0] Q30_PI      = 34'sd3373259426;
   localparam logic signed [Q_W-1:0] Q30_HALF_PI = 34'sd1686629713;
   localparam logic signed [Q_W-1:0] Q30_TWO_PI  = 34'sd6746518852;
   localparam logic signed [Q_W-1:0] Q30_GAIN    = 34'sd652032874;

   localparam logic [IN_W-1:0] OUT_ONE =
      (FRAC_BITS >= IN_W - 1) ? 16'h7FFF : IN_W'(64'd1 << FRAC_BITS);

   // products of axis components kept along the CORDIC pipe
   localparam int UV_XX = 0;
   localparam int UV_XY = 1;
   localparam int UV_XZ = 2;
   localparam int UV_YY = 3;
   localparam int UV_YZ = 4;
   localparam int UV_ZZ = 5;
   localparam int AX_I  = 0;
   localparam int AY_I  = 1;
   localparam int AZ_I  = 2;

   typedef struct packed {
      logic signed [IN_W-1:0] ax;
      logic signed [IN_W-1:0] ay;
      logic signed [IN_W-1:0] az;
      logic signed [Q_W-1:0]  ang;
   } item_type;

   typedef struct packed {
      logic [2:0][IN_W-1:0] a;
      logic [5:0][UV_W-1:0] uv;
   } carry_type;

   typedef struct packed {
      logic [8:0][IN_W-1:0] e;
   } mat_type;

   function automatic logic signed [Q_W-1:0] atan_q30(input int idx);
      logic signed [Q_W-1:0] r;
      case (idx)
         0:  r = 34'sd843314857;
         1:  r = 34'sd497837829;
         2:  r = 34'sd263043837;
         3:  r = 34'sd133525159;
         4:  r = 34'sd67021687;
         5:  r = 34'sd33543516;
         6:  r = 34'sd16775851;
         7:  r = 34'sd8388437;
         8:  r = 34'sd4194283;
         9:  r = 34'sd2097149;
         10: r = 34'sd1048576;
         11: r = 34'sd524288;
         12: r = 34'sd262144;
         13: r = 34'sd131072;
         14: r = 34'sd65536;
         15: r = 34'sd32768;
         16: r = 34'sd16384;
         17: r = 34'sd8192;
         18: r = 34'sd4096;
         19: r = 34'sd2048;
         20: r = 34'sd1024;
         21: r = 34'sd512;
         22: r = 34'sd256;
         23: r = 34'sd128;
         24: r = 34'sd64;
         25: r = 34'sd32;
         26: r = 34'sd16;
         27: r = 34'sd8;
         28: r = 34'sd4;
         29: r = 34'sd2;
         30: r = 34'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

   // round Q30 to FRAC_BITS (add half, floor), then clamp to 16 bits signed
   function automatic logic [IN_W-1:0] round_sat(input logic signed [E_W-1:0] v);
      logic signed [E_W-1:0] r;
      r = (v + (E_W'(1) <<< (RND_SHIFT - 1))) >>> RND_SHIFT;
      if (r > E_W'(32767))
         return 16'h7FFF;
      else if (r < -E_W'(32768))
         return 16'h8000;
      else
         return r[IN_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/aarm_front.sv =====
// Front end: takes requests, wraps the angle into [-pi, pi], queues them for the back end.
`default_nettype none
module aarm_front import aarm_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic signed [IN_W-1:0] req_axis_x,
   input  wire logic signed [IN_W-1:0] req_axis_y,
   input  wire logic signed [IN_W-1:0] req_axis_z,
   input  wire logic signed [IN_W-1:0] req_angle_rad,
   input  wire logic                   pop,
   output logic                        q_valid,
   output item_type                    q_head
);

   localparam int DEPTH = 2;

   item_type              q_mem [DEPTH];
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic [1:0]            cnt_ff, cnt_in;
   logic                  push;
   logic signed [Q_W-1:0] z0, zw;
   item_type              item;

   assign busy    = (cnt_ff == 2'(DEPTH));
   assign push    = start && !busy;
   assign q_valid = (cnt_ff != '0);
   assign q_head  = q_mem[rd_ptr_ff];

   always_comb begin
      z0 = Q_W'(req_angle_rad) <<< ANG_SHIFT;
      if (z0 > Q30_PI)
         zw = z0 - Q30_TWO_PI;
      else if (z0 < -Q30_PI)
         zw = z0 + Q30_TWO_PI;
      else
         zw = z0;
      item.ax  = req_axis_x;
      item.ay  = req_axis_y;
      item.az  = req_axis_z;
      item.ang = zw;
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push)
         q_mem[wr_ptr_ff] <= item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/aarm_back.sv =====
// Back end: paces queued items into CORDIC and matrix pipeline via a gap counter.
`default_nettype none
module aarm_back import aarm_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     q_valid,
   input  item_type      q_head,
   output logic          pop,
   output logic          mat_vld,
   output mat_type       mat
);

   logic [1:0] gap_ff, gap_in;

   logic signed [Q_W-1:0] x_ff [0:CORDIC_STEPS];
   logic signed [Q_W-1:0] y_ff [0:CORDIC_STEPS];
   logic signed [Q_W-1:0] z_ff [0:CORDIC_STEPS];
   logic                  neg_ff [0:CORDIC_STEPS];
   logic                  vld_ff [0:CORDIC_STEPS];
   carry_type             cy_ff  [0:CORDIC_STEPS];

   logic signed [Q_W-1:0] zf;
   logic                  negf;
   carry_type             cy0;

   // post-CORDIC stages
   logic                  p1_vld_ff, p2_vld_ff, p3_vld_ff, p4_vld_ff;
   logic signed [Q_W-1:0] c1_ff, s1_ff, omc1_ff;
   carry_type             cy1_ff;
   logic signed [Q_W-1:0] c2_ff;
   logic signed [PH_W-1:0] ph_ff [6];
   logic signed [PL_W-1:0] pl_ff [6];
   logic signed [SN_W-1:0] sn_ff [3];
   logic signed [E_W-1:0]  c3_ff;
   logic signed [E_W-1:0]  ot_ff [6];
   logic signed [E_W-1:0]  st_ff [3];
   logic signed [E_W-1:0]  m [9];
   mat_type                mat_ff;

   assign pop     = q_valid && (gap_ff == '0);
   assign mat_vld = p4_vld_ff;
   assign mat     = mat_ff;

   always_comb begin
      gap_in = pop ? 2'(NUM_ROWS - 1) : ((gap_ff != '0) ? gap_ff - 2'd1 : gap_ff);
      negf = 1'b0;
      zf   = q_head.ang;
      if (q_head.ang > Q30_HALF_PI) begin
         zf   = q_head.ang - Q30_PI;
         negf = 1'b1;
      end else if (q_head.ang < -Q30_HALF_PI) begin
         zf   = q_head.ang + Q30_PI;
         negf = 1'b1;
      end
      cy0.a[AX_I]   = q_head.ax;
      cy0.a[AY_I]   = q_head.ay;
      cy0.a[AZ_I]   = q_head.az;
      cy0.uv[UV_XX] = q_head.ax * q_head.ax;
      cy0.uv[UV_XY] = q_head.ax * q_head.ay;
      cy0.uv[UV_XZ] = q_head.ax * q_head.az;
      cy0.uv[UV_YY] = q_head.ay * q_head.ay;
      cy0.uv[UV_YZ] = q_head.ay * q_head.az;
      cy0.uv[UV_ZZ] = q_head.az * q_head.az;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff    <= '0;
         vld_ff[0] <= 1'b0;
      end else begin
         gap_ff    <= gap_in;
         vld_ff[0] <= pop;
      end
   end

   always_ff @(posedge clock) begin
      x_ff[0]   <= Q30_GAIN;
      y_ff[0]   <= '0;
      z_ff[0]   <= zf;
      neg_ff[0] <= negf;
      cy_ff[0]  <= cy0;
   end

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
      logic signed [Q_W-1:0] dx, dy;
      assign dx = y_ff[k] >>> k;
      assign dy = x_ff[k] >>> k;

      always_ff @(posedge clock) begin
         if (reset)
            vld_ff[k+1] <= 1'b0;
         else
            vld_ff[k+1] <= vld_ff[k];
      end

      always_ff @(posedge clock) begin
         if (!z_ff[k][Q_W-1]) begin
            x_ff[k+1] <= x_ff[k] - dx;
            y_ff[k+1] <= y_ff[k] + dy;
            z_ff[k+1] <= z_ff[k] - atan_q30(k);
         end else begin
            x_ff[k+1] <= x_ff[k] + dx;
            y_ff[k+1] <= y_ff[k] - dy;
            z_ff[k+1] <= z_ff[k] + atan_q30(k);
         end
         neg_ff[k+1] <= neg_ff[k];
         cy_ff[k+1]  <= cy_ff[k];
      end
   end

   always_comb begin
      m[0] = c3_ff + ot_ff[UV_XX];
      m[1] = ot_ff[UV_XY] - st_ff[AZ_I];
      m[2] = ot_ff[UV_XZ] + st_ff[AY_I];
      m[3] = ot_ff[UV_XY] + st_ff[AZ_I];
      m[4] = c3_ff + ot_ff[UV_YY];
      m[5] = ot_ff[UV_YZ] - st_ff[AX_I];
      m[6] = ot_ff[UV_XZ] - st_ff[AY_I];
      m[7] = ot_ff[UV_YZ] + st_ff[AX_I];
      m[8] = c3_ff + ot_ff[UV_ZZ];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
         p3_vld_ff <= 1'b0;
         p4_vld_ff <= 1'b0;
      end else begin
         p1_vld_ff <= vld_ff[CORDIC_STEPS];
         p2_vld_ff <= p1_vld_ff;
         p3_vld_ff <= p2_vld_ff;
         p4_vld_ff <= p3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      // undo the half-turn fold: c, s negated; omc = 1 - c
      if (neg_ff[CORDIC_STEPS]) begin
         c1_ff   <= -x_ff[CORDIC_STEPS];
         s1_ff   <= -y_ff[CORDIC_STEPS];
         omc1_ff <= Q30_ONE + x_ff[CORDIC_STEPS];
      end else begin
         c1_ff   <= x_ff[CORDIC_STEPS];
         s1_ff   <= y_ff[CORDIC_STEPS];
         omc1_ff <= Q30_ONE - x_ff[CORDIC_STEPS];
      end
      cy1_ff <= cy_ff[CORDIC_STEPS];

      // omc split into signed high and unsigned low halves
      for (int j = 0; j < 6; j++) begin
         ph_ff[j] <= $signed(cy1_ff.uv[j]) * $signed(omc1_ff[Q_W-1:16]);
         pl_ff[j] <= $signed(cy1_ff.uv[j]) * $signed({1'b0, omc1_ff[15:0]});
      end
      for (int j = 0; j < 3; j++)
         sn_ff[j] <= $signed(cy1_ff.a[j]) * s1_ff;
      c2_ff  <= c1_ff;

      for (int j = 0; j < 6; j++)
         ot_ff[j] <= E_W'(((PW'(ph_ff[j]) <<< 16) + PW'(pl_ff[j])) >>> OUTER_SHIFT);
      for (int j = 0; j < 3; j++)
         st_ff[j] <= E_W'(sn_ff[j] >>> SIN_SHIFT);
      c3_ff <= E_W'(c2_ff);

      for (int j = 0; j < 9; j++)
         mat_ff.e[j] <= round_sat(m[j]);
   end

endmodule
`default_nettype wire

// ===== rtl/aarm_rowout.sv =====
// Result serializer: sends a finished matrix as four row transactions on consecutive cycles.
`default_nettype none
module aarm_rowout import aarm_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        mat_vld,
   input  mat_type          mat,
   output logic             rsp_strobe,
   output logic [1:0]       rsp_row_index,
   output logic [IN_W-1:0]  rsp_col0,
   output logic [IN_W-1:0]  rsp_col1,
   output logic [IN_W-1:0]  rsp_col2,
   output logic [IN_W-1:0]  rsp_col3,
   output logic             rsp_last_row
);

   mat_type         mat_ff;
   logic            act_ff, act_in;
   logic [1:0]      cnt_ff, cnt_in;
   logic            stb_ff, stb_in;
   logic [1:0]      idx_ff, idx_in;
   logic [IN_W-1:0] c0_ff, c1_ff, c2_ff, c3_ff;
   logic [IN_W-1:0] c0_in, c1_in, c2_in, c3_in;
   logic            last_ff, last_in;

   assign rsp_strobe    = stb_ff;
   assign rsp_row_index = idx_ff;
   assign rsp_col0      = c0_ff;
   assign rsp_col1      = c1_ff;
   assign rsp_col2      = c2_ff;
   assign rsp_col3      = c3_ff;
   assign rsp_last_row  = last_ff;

   always_comb begin
      act_in  = act_ff;
      cnt_in  = cnt_ff;
      stb_in  = 1'b0;
      idx_in  = cnt_ff;
      c0_in   = '0;
      c1_in   = '0;
      c2_in   = '0;
      c3_in   = '0;
      last_in = 1'b0;
      if (mat_vld) begin
         stb_in = 1'b1;
         idx_in = 2'd0;
         c0_in  = mat.e[0];
         c1_in  = mat.e[1];
         c2_in  = mat.e[2];
         act_in = 1'b1;
         cnt_in = 2'd1;
      end else if (act_ff) begin
         stb_in = 1'b1;
         cnt_in = cnt_ff + 2'd1;
         case (cnt_ff)
            2'd1: begin
               c0_in = mat_ff.e[3];
               c1_in = mat_ff.e[4];
               c2_in = mat_ff.e[5];
            end
            2'd2: begin
               c0_in = mat_ff.e[6];
               c1_in = mat_ff.e[7];
               c2_in = mat_ff.e[8];
            end
            default: begin
               c3_in   = OUT_ONE;
               last_in = 1'b1;
               act_in  = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mat_vld)
         mat_ff <= mat;
      idx_ff  <= idx_in;
      c0_ff   <= c0_in;
      c1_ff   <= c1_in;
      c2_ff   <= c2_in;
      c3_ff   <= c3_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
         cnt_ff <= '0;
         stb_ff <= 1'b0;
      end else begin
         act_ff <= act_in;
         cnt_ff <= cnt_in;
         stb_ff <= stb_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/axis_angle_rotation_matrix_core.sv =====
// Row 0 passes the queue, CORDIC pipe, matrix stages and row register; rows 1..3 on the next cycles.
// Issue pacing: the back end spaces items so the four row results fit on the one result port;
//   a two-entry queue lets requests arrive back to back until it fills (busy high).
// The receiver cannot stall: each row is on the rsp_ ports for one cycle with rsp_strobe.
// Reset (synchronous) empties the queue and the pipeline; no results are pending after it.
`default_nettype none
module axis_angle_rotation_matrix_core import aarm_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic signed [IN_W-1:0] req_axis_x,
   input  wire logic signed [IN_W-1:0] req_axis_y,
   input  wire logic signed [IN_W-1:0] req_axis_z,
   input  wire logic signed [IN_W-1:0] req_angle_rad,
   output logic                        rsp_strobe,
   output logic [1:0]                  rsp_row_index,
   output logic signed [IN_W-1:0]      rsp_col0,
   output logic signed [IN_W-1:0]      rsp_col1,
   output logic signed [IN_W-1:0]      rsp_col2,
   output logic signed [IN_W-1:0]      rsp_col3,
   output logic                        rsp_last_row
);

   logic     q_valid;
   item_type q_head;
   logic     pop;
   logic     mat_vld;
   mat_type  mat;

   aarm_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_axis_x    (req_axis_x),
      .req_axis_y    (req_axis_y),
      .req_axis_z    (req_axis_z),
      .req_angle_rad (req_angle_rad),
      .pop           (pop),
      .q_valid       (q_valid),
      .q_head        (q_head)
   );

   aarm_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_head  (q_head),
      .pop     (pop),
      .mat_vld (mat_vld),
      .mat     (mat)
   );

   aarm_rowout u_rowout (
      .clock         (clock),
      .reset         (reset),
      .mat_vld       (mat_vld),
      .mat           (mat),
      .rsp_strobe    (rsp_strobe),
      .rsp_row_index (rsp_row_index),
      .rsp_col0      (rsp_col0),
      .rsp_col1      (rsp_col1),
      .rsp_col2      (rsp_col2),
      .rsp_col3      (rsp_col3),
      .rsp_last_row  (rsp_last_row)
   );

   // rows of one matrix go out in order with no gap
   a_row_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_row |=>
         rsp_strobe && (rsp_row_index == $past(rsp_row_index) + 2'd1))
      else $error("row sequence broken");

   a_last_row: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_last_row == (rsp_row_index == 2'd3)))
      else $error("last_row flag mismatch");

   // issue spacing keeps finished matrices apart, so each row sequence ends before the next matrix arrives
   a_mat_space: assert property (@(posedge clock) disable iff (reset)
      mat_vld |=> !mat_vld ##1 !mat_vld ##1 !mat_vld)
      else $error("matrix results too close");

   a_pop_space: assert property (@(posedge clock) disable iff (reset)
      pop |=> !pop)
      else $error("queue popped on consecutive cycles");

endmodule
`default_nettype wire
